// ===== hw/rtl/cdt_pkg.sv =====
// shared types and constants of the chamfer distance transform block
// no dependencies; imported by cdt_ctrl, cdt_datapath, the top level and the testbench
`default_nettype none

package cdt_pkg;

  localparam int DIST_W  = 24;
  localparam int FRAME_W = 9;
  localparam int COORD_W = FRAME_W + 2;

  localparam logic [DIST_W-1:0] DIST_MAX      = 24'hFFFFFF;
  localparam logic [DIST_W-1:0] STEP_STRAIGHT = 24'd256;
  localparam logic [DIST_W-1:0] STEP_DIAGONAL = 24'd362;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_WRAP_EDGES   = 2'd2;

  // how the datapath uses the word coming back from the store
  typedef enum logic [2:0] {
    TAG_NONE,
    TAG_HOST,
    TAG_CENTER,
    TAG_STRAIGHT,
    TAG_DIAG
  } tag_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_load;
    logic load_unreached;
    logic zero;
    tag_t tag;
  } cdt_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cdt_ctrl.sv =====
// controller: command decode, scan state machine and store address generation
// depends on cdt_pkg
`default_nettype none

module cdt_ctrl #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output      logic                                  busy,
  input  wire logic [1:0]                            in_mode,
  input  wire logic [7:0]                            in_pixel_x,
  input  wire logic [7:0]                            in_pixel_y,
  input  wire logic [7:0]                            in_alpha,
  input  wire logic [cdt_pkg::FRAME_W-1:0]           frame_width,
  input  wire logic [cdt_pkg::FRAME_W-1:0]           frame_height,
  input  wire logic                                  wrap_edges,
  output      cdt_pkg::cdt_cmd_t                     cmd,
  output      logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] mem_addr
);
  import cdt_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam logic [2:0] PH_CENTER = 3'd0;
  localparam logic [2:0] PH_WRITE  = 3'd5;

  typedef enum logic [1:0] {ST_IDLE, ST_FWD, ST_BWD} state_t;

  state_t             state_r, state_nxt;
  logic [FRAME_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic [2:0]         phase_r, phase_nxt;

  logic [FRAME_W-1:0] act_w, act_h;
  logic               host_inside;
  logic               fwd;
  logic signed [COORD_W-1:0] s, dx, dy, nx_raw, ny_raw, nx, ny, act_ws, act_hs;
  logic               out_x, out_y, nb_zero;

  function automatic logic [ADDR_W-1:0] pixel_index(input logic [FRAME_W-1:0] col,
                                                    input logic [FRAME_W-1:0] row);
    return ADDR_W'(row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col);
  endfunction

  assign act_w = (32'(frame_width) > MAX_WIDTH) ? FRAME_W'(MAX_WIDTH) : frame_width;
  assign act_h = (32'(frame_height) > MAX_HEIGHT) ? FRAME_W'(MAX_HEIGHT) : frame_height;
  assign host_inside = (32'(in_pixel_x) < MAX_WIDTH) && (32'(in_pixel_y) < MAX_HEIGHT);
  assign busy = (state_r != ST_IDLE);
  assign fwd  = (state_r == ST_FWD);

  // neighbour offsets: forward pass looks back, backward pass looks ahead
  assign s = fwd ? -COORD_W'(1) : COORD_W'(1);
  always_comb begin
    case (phase_r)
      3'd1:    begin dx = s;  dy = '0; end
      3'd2:    begin dx = '0; dy = s;  end
      3'd3:    begin dx = s;  dy = s;  end
      3'd4:    begin dx = -s; dy = s;  end
      default: begin dx = '0; dy = '0; end
    endcase
  end

  assign act_ws = $signed({2'b00, act_w});
  assign act_hs = $signed({2'b00, act_h});
  assign nx_raw = $signed({2'b00, x_r}) + dx;
  assign ny_raw = $signed({2'b00, y_r}) + dy;
  assign out_x  = (nx_raw < 0) || (nx_raw >= act_ws);
  assign out_y  = (ny_raw < 0) || (ny_raw >= act_hs);
  assign nb_zero = (out_x || out_y) && !wrap_edges;

  always_comb begin
    nx = nx_raw;
    ny = ny_raw;
    if (nx_raw < 0) nx = nx_raw + act_ws;
    else if (nx_raw >= act_ws) nx = nx_raw - act_ws;
    if (ny_raw < 0) ny = ny_raw + act_hs;
    else if (ny_raw >= act_hs) ny = ny_raw - act_hs;
  end

  // commands to the datapath
  always_comb begin
    cmd = '{rd_en: 1'b0, wr_en: 1'b0, wr_load: 1'b0, load_unreached: 1'b0,
            zero: 1'b0, tag: TAG_NONE};
    mem_addr = '0;
    unique case (state_r) inside
      ST_IDLE: begin
        if (start) begin
          mem_addr = pixel_index({1'b0, in_pixel_x}, {1'b0, in_pixel_y});
          unique case (in_mode)
            MODE_LOAD: begin
              cmd.wr_en          = host_inside;
              cmd.wr_load        = 1'b1;
              cmd.load_unreached = in_alpha[7];
            end
            MODE_READ: begin
              cmd.rd_en = host_inside;
              cmd.zero  = !host_inside;
              cmd.tag   = TAG_HOST;
            end
            default: ;
          endcase
        end
      end
      ST_FWD, ST_BWD: begin
        if (phase_r == PH_CENTER) begin
          mem_addr  = pixel_index(x_r, y_r);
          cmd.rd_en = 1'b1;
          cmd.tag   = TAG_CENTER;
        end else if (phase_r == PH_WRITE) begin
          mem_addr  = pixel_index(x_r, y_r);
          cmd.wr_en = 1'b1;
        end else begin
          mem_addr  = pixel_index(nx[FRAME_W-1:0], ny[FRAME_W-1:0]);
          cmd.rd_en = !nb_zero;
          cmd.zero  = nb_zero;
          cmd.tag   = (phase_r >= 3'd3) ? TAG_DIAG : TAG_STRAIGHT;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    phase_nxt = phase_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_mode == MODE_RUN && act_w != '0 && act_h != '0) begin
          state_nxt = ST_FWD;
          x_nxt     = '0;
          y_nxt     = '0;
          phase_nxt = PH_CENTER;
        end
      end
      ST_FWD: begin
        phase_nxt = phase_r + 3'd1;
        if (phase_r == PH_WRITE) begin
          phase_nxt = PH_CENTER;
          if (x_r == act_w - 1'b1) begin
            x_nxt = '0;
            if (y_r == act_h - 1'b1) begin
              state_nxt = ST_BWD;
              x_nxt     = act_w - 1'b1;
              y_nxt     = act_h - 1'b1;
            end else begin
              y_nxt = y_r + 1'b1;
            end
          end else begin
            x_nxt = x_r + 1'b1;
          end
        end
      end
      ST_BWD: begin
        phase_nxt = phase_r + 3'd1;
        if (phase_r == PH_WRITE) begin
          phase_nxt = PH_CENTER;
          if (x_r == '0) begin
            x_nxt = act_w - 1'b1;
            if (y_r == '0) state_nxt = ST_IDLE;
            else           y_nxt = y_r - 1'b1;
          end else begin
            x_nxt = x_r - 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      x_r     <= '0;
      y_r     <= '0;
      phase_r <= PH_CENTER;
    end else begin
      state_r <= state_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cdt_datapath.sv =====
// datapath: distance store, saturating relax unit and read-out register
// depends on cdt_pkg
`default_nettype none

module cdt_datapath #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire cdt_pkg::cdt_cmd_t                       cmd,
  input  wire logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] mem_addr,
  output      logic                                    out_valid,
  output      logic [cdt_pkg::DIST_W-1:0]              out_distance
);
  import cdt_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  logic [DIST_W-1:0] mem [DEPTH];
  logic [DIST_W-1:0] rdata_r;
  tag_t              tag_r;
  logic              zero_r;
  logic [DIST_W-1:0] best_r, best_nxt;
  logic [DIST_W-1:0] opnd, step, sat, wdata;
  logic [DIST_W:0]   sum;

  assign opnd = zero_r ? '0 : rdata_r;
  assign step = (tag_r == TAG_DIAG) ? STEP_DIAGONAL : STEP_STRAIGHT;
  assign sum  = {1'b0, opnd} + {1'b0, step};
  assign sat  = (sum > {1'b0, DIST_MAX}) ? DIST_MAX : sum[DIST_W-1:0];

  always_comb begin
    case (tag_r) inside
      TAG_CENTER:             best_nxt = rdata_r;
      TAG_STRAIGHT, TAG_DIAG: best_nxt = (sat < best_r) ? sat : best_r;
      default:                best_nxt = best_r;
    endcase
  end

  // the write of a run pixel takes the minimum including the last neighbour beat
  assign wdata = cmd.wr_load ? (cmd.load_unreached ? DIST_MAX : '0) : best_nxt;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[mem_addr] <= wdata;
    if (cmd.rd_en) rdata_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
    zero_r <= cmd.zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tag_r <= TAG_NONE;
    else        tag_r <= cmd.tag;
  end

  assign out_valid    = (tag_r == TAG_HOST);
  assign out_distance = opnd;

endmodule

`default_nettype wire

// ===== hw/rtl/chamfer_distance_transform_top.sv =====
// top level of the 3x3 chamfer distance transform: configuration registers,
// controller and datapath; depends on cdt_pkg, cdt_ctrl and cdt_datapath
`default_nettype none

// Loads and reads can be issued back to back; busy stays low for them. A read
// returns its distance on out_distance with out_valid high for exactly one
// cycle, the cycle after it was accepted; the receiver must take it then. A run
// raises busy the cycle after it is accepted and holds it while both passes walk
// the w by h frame (the frame size clamped to MAX_WIDTH and MAX_HEIGHT): each
// pass reads a pixel, reads its four neighbours (zero outside an unwrapped
// frame) and writes it through the single port of the distance store. A run
// with a zero-sized frame does nothing and busy never rises. Every pixel of the
// frame must be loaded before a run; the store is not cleared at reset.
module chamfer_distance_transform_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output      logic                         busy,
  input  wire logic [1:0]                   in_mode,
  input  wire logic [7:0]                   in_pixel_x,
  input  wire logic [7:0]                   in_pixel_y,
  input  wire logic [7:0]                   in_alpha,
  output      logic                         out_valid,
  output      logic [cdt_pkg::DIST_W-1:0]   out_distance,
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [cdt_pkg::FRAME_W-1:0]  cfg_wdata
);
  import cdt_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT);

  logic [FRAME_W-1:0] frame_width_r, frame_height_r;
  logic               wrap_edges_r;
  cdt_cmd_t           cmd;
  logic [ADDR_W-1:0]  mem_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_W'(256);
      frame_height_r <= FRAME_W'(256);
      wrap_edges_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        REG_WRAP_EDGES:   wrap_edges_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  cdt_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .in_alpha     (in_alpha),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .wrap_edges   (wrap_edges_r),
    .cmd          (cmd),
    .mem_addr     (mem_addr)
  );

  cdt_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .mem_addr     (mem_addr),
    .out_valid    (out_valid),
    .out_distance (out_distance)
  );

endmodule

`default_nettype wire

// ===== sim/cdt_tb_pkg.sv =====
// scoreboard for the chamfer distance transform testbench: a bit-accurate
// predictor of the distance store and a queue of expected read distances
// depends on cdt_pkg for the mode and register codes
`timescale 1ns / 100ps

package cdt_tb_pkg;

  import cdt_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         STORE_SIDE  = 256;
  localparam bit [23:0]  UNREACHED   = 24'hFFFFFF;
  localparam bit [23:0]  ORTHO_STEP  = 24'd256;
  localparam bit [23:0]  DIAG_STEP   = 24'd362;

  class cdt_scoreboard;
    bit [23:0] dist_mem [STORE_SIDE*STORE_SIDE];
    bit [8:0]  width_reg;
    bit [8:0]  height_reg;
    bit        wrap_reg;
    int        run_cols;
    int        run_rows;
    bit [23:0] pending_q [$];
    int        errors;

    function new();
      width_reg  = 9'd256;
      height_reg = 9'd256;
      wrap_reg   = 1'b0;
      errors     = 0;
    endfunction

    function void write_reg(input logic [1:0] index, input logic [8:0] value);
      case (index)
        REG_FRAME_WIDTH:  width_reg = value;
        REG_FRAME_HEIGHT: height_reg = value;
        REG_WRAP_EDGES:   wrap_reg = value[0];
        default: ;
      endcase
    endfunction

    // outside the frame reads as outline unless the edges wrap
    function bit [23:0] probe(input int x, input int y);
      if (x < 0 || y < 0 || x >= run_cols || y >= run_rows) begin
        if (!wrap_reg) return 24'd0;
        if (x < 0) x += run_cols;
        else if (x >= run_cols) x -= run_cols;
        if (y < 0) y += run_rows;
        else if (y >= run_rows) y -= run_rows;
      end
      return dist_mem[y*STORE_SIDE + x];
    endfunction

    function bit [23:0] relax(input bit [23:0] best, input bit [23:0] nb,
                              input bit [23:0] step);
      bit [24:0] sum;
      sum = nb + step;
      if (sum > UNREACHED) sum = UNREACHED;
      return (sum[23:0] < best) ? sum[23:0] : best;
    endfunction

    function void chamfer_run();
      bit [23:0] b;
      int        x;
      int        y;
      run_cols = (width_reg > STORE_SIDE) ? STORE_SIDE : width_reg;
      run_rows = (height_reg > STORE_SIDE) ? STORE_SIDE : height_reg;
      if (run_cols == 0 || run_rows == 0) return;
      for (y = 0; y < run_rows; y++) begin
        for (x = 0; x < run_cols; x++) begin
          b = dist_mem[y*STORE_SIDE + x];
          b = relax(b, probe(x - 1, y), ORTHO_STEP);
          b = relax(b, probe(x, y - 1), ORTHO_STEP);
          b = relax(b, probe(x - 1, y - 1), DIAG_STEP);
          b = relax(b, probe(x + 1, y - 1), DIAG_STEP);
          dist_mem[y*STORE_SIDE + x] = b;
        end
      end
      for (y = run_rows - 1; y >= 0; y--) begin
        for (x = run_cols - 1; x >= 0; x--) begin
          b = dist_mem[y*STORE_SIDE + x];
          b = relax(b, probe(x + 1, y), ORTHO_STEP);
          b = relax(b, probe(x, y + 1), ORTHO_STEP);
          b = relax(b, probe(x + 1, y + 1), DIAG_STEP);
          b = relax(b, probe(x - 1, y + 1), DIAG_STEP);
          dist_mem[y*STORE_SIDE + x] = b;
        end
      end
    endfunction

    function void note_beat(input logic [1:0] mode, input logic [7:0] px,
                            input logic [7:0] py, input logic [7:0] alpha);
      case (mode)
        MODE_LOAD: dist_mem[{py, px}] = (alpha < 8'd128) ? 24'd0 : UNREACHED;
        MODE_RUN:  chamfer_run();
        MODE_READ: pending_q.push_back(dist_mem[{py, px}]);
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void check_distance(input logic [23:0] got);
      bit [23:0] want;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: distance beat with none expected, got %h", $time, got);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: distance expected %h got %h", $time, want, got);
      end
    endfunction
  endclass

endpackage

// ===== sim/tb_top.sv =====
// top of the chamfer distance transform testbench: clock, reset, command and
// configuration drivers, result monitor; depends on cdt_pkg and cdt_tb_pkg
`timescale 1ns / 100ps

module tb_top;

  import cdt_pkg::*;
  import cdt_tb_pkg::*;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 start        = 1'b0;
  logic                 busy;
  logic [1:0]           in_mode      = MODE_LOAD;
  logic [7:0]           in_pixel_x   = 8'd0;
  logic [7:0]           in_pixel_y   = 8'd0;
  logic [7:0]           in_alpha     = 8'd0;
  logic                 out_valid;
  logic [DIST_W-1:0]    out_distance;
  logic                 cfg_we       = 1'b0;
  logic [1:0]           cfg_index    = REG_FRAME_WIDTH;
  logic [FRAME_W-1:0]   cfg_wdata    = '0;

  cdt_scoreboard sb;
  int idle_pct;
  int outline_pct;
  int frame_cols;
  int frame_rows;
  bit loaded [STORE_SIDE*STORE_SIDE];
  int loaded_addr [$];

  chamfer_distance_transform_top uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .in_alpha     (in_alpha),
    .out_valid    (out_valid),
    .out_distance (out_distance),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_distance(out_distance);
  end

  // holds the beat until the block takes it, then maybe leaves a gap
  task automatic issue(input logic [1:0] mode, input logic [7:0] px,
                       input logic [7:0] py, input logic [7:0] alpha);
    start      <= 1'b1;
    in_mode    <= mode;
    in_pixel_x <= px;
    in_pixel_y <= py;
    in_alpha   <= alpha;
    do @(posedge clk); while (busy);
    sb.note_beat(mode, px, py, alpha);
    if (mode == MODE_LOAD && !loaded[{py, px}]) begin
      loaded[{py, px}] = 1'b1;
      loaded_addr.push_back({py, px});
    end
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [7:0] pick_alpha();
    if ($urandom_range(99) < outline_pct) return $urandom_range(127);
    return $urandom_range(255, 128);
  endfunction

  // drains outstanding reads and any run still walking the frame
  task automatic settle();
    start <= 1'b0;
    repeat (4) @(posedge clk);
    while (busy || sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_frame(input logic [8:0] w, input logic [8:0] h, input bit wrap);
    logic [7:0] junk;
    junk      = $urandom_range(255);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    sb.write_reg(REG_FRAME_WIDTH, w);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    sb.write_reg(REG_FRAME_HEIGHT, h);
    // only bit 0 of the wrap write counts
    cfg_index <= REG_WRAP_EDGES;
    cfg_wdata <= {junk, wrap};
    @(posedge clk);
    sb.write_reg(REG_WRAP_EDGES, {junk, wrap});
    cfg_we     <= 1'b0;
    frame_cols = (w > STORE_SIDE) ? STORE_SIDE : w;
    frame_rows = (h > STORE_SIDE) ? STORE_SIDE : h;
  endtask

  task automatic load_frame();
    for (int y = 0; y < frame_rows; y++) begin
      for (int x = 0; x < frame_cols; x++) issue(MODE_LOAD, x, y, pick_alpha());
    end
  endtask

  task automatic read_loaded();
    int a;
    a = loaded_addr[$urandom_range(loaded_addr.size() - 1)];
    issue(MODE_READ, a[7:0], a[15:8], $urandom_range(255));
  endtask

  task automatic random_ops(input int count);
    int  r;
    bit  has_frame;
    has_frame = (frame_cols * frame_rows) > 0;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 40 && has_frame)
        issue(MODE_READ, $urandom_range(frame_cols - 1), $urandom_range(frame_rows - 1),
              $urandom_range(255));
      else if (r < 55 && has_frame)
        issue(MODE_LOAD, $urandom_range(frame_cols - 1), $urandom_range(frame_rows - 1),
              pick_alpha());
      else if (r < 63)
        issue(MODE_LOAD, $urandom_range(255), $urandom_range(255), $urandom_range(255));
      else if (r < 75)
        issue(MODE_RUN, $urandom_range(255), $urandom_range(255), $urandom_range(255));
      else if (r < 80)
        issue(MODE_UNUSED, $urandom_range(255), $urandom_range(255), $urandom_range(255));
      else
        read_loaded();
    end
  endtask

  initial begin
    sb          = new();
    idle_pct    = 0;
    outline_pct = 30;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: small frame, alpha around the outline threshold, store corners
    set_frame(9'd3, 9'd2, 1'b0);
    issue(MODE_LOAD, 8'd0, 8'd0, 8'd0);
    issue(MODE_LOAD, 8'd1, 8'd0, 8'd127);
    issue(MODE_LOAD, 8'd2, 8'd0, 8'd128);
    issue(MODE_LOAD, 8'd0, 8'd1, 8'd255);
    issue(MODE_LOAD, 8'd1, 8'd1, 8'd200);
    issue(MODE_LOAD, 8'd2, 8'd1, 8'd255);
    issue(MODE_LOAD, 8'd255, 8'd0, 8'd255);
    issue(MODE_LOAD, 8'd0, 8'd255, 8'd64);
    issue(MODE_LOAD, 8'd255, 8'd255, 8'd128);
    issue(MODE_UNUSED, 8'd255, 8'd255, 8'd255);
    issue(MODE_READ, 8'd255, 8'd255, 8'd0);
    issue(MODE_READ, 8'd0, 8'd255, 8'd0);
    issue(MODE_READ, 8'd2, 8'd0, 8'd0);
    issue(MODE_RUN, 8'd0, 8'd0, 8'd0);
    issue(MODE_READ, 8'd0, 8'd1, 8'd0);
    issue(MODE_READ, 8'd1, 8'd1, 8'd0);
    issue(MODE_READ, 8'd2, 8'd1, 8'd0);
    issue(MODE_READ, 8'd2, 8'd0, 8'd0);
    issue(MODE_READ, 8'd255, 8'd0, 8'd0);
    // second run continues from the current distances
    issue(MODE_RUN, 8'd255, 8'd255, 8'd255);
    issue(MODE_READ, 8'd2, 8'd1, 8'd0);
    issue(MODE_READ, 8'd0, 8'd0, 8'd0);
    settle();

    // full-width and oversized frames, self-wrapping pixel, zero frames, then random
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: set_frame(9'd256, 9'd1, 1'b0);
        1: set_frame(9'd1, 9'd511, 1'b1);
        2: set_frame(9'd1, 9'd1, 1'b1);
        3: set_frame(9'd0, 9'd7, 1'b0);
        4: set_frame(9'd6, 9'd0, 1'b1);
        default: set_frame($urandom_range(1, 9), $urandom_range(1, 9), $urandom_range(1));
      endcase
      idle_pct    = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 86 : 19);
      outline_pct = (p == 2 || p == 8) ? 0 : $urandom_range(3, 40);
      load_frame();
      random_ops((p < 5) ? 25 : 40);
      settle();
    end

    if (sb.errors == 0 && sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
